@@ hdl/rpwc_pkg.sv @@
package rpwc_pkg;

    localparam int CHANNELS_DEF = 4;

    localparam int CH_W   = 2;
    localparam int TS_W   = 32;
    localparam int WID_W  = 16;
    localparam int CFG_W  = 16;
    localparam int CFG_AW = 3;

    localparam int S_DATA_W = ((CH_W + TS_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((CH_W + WID_W + 7) / 8) * 8;

    localparam logic [CFG_AW-1:0] CFG_MIN_WIDTH    = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] CFG_MAX_WIDTH    = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] CFG_DEAD_LOW     = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] CFG_DEAD_HIGH    = CFG_AW'(3);
    localparam logic [CFG_AW-1:0] CFG_CENTER_WIDTH = CFG_AW'(4);

    localparam logic [CFG_W-1:0] RST_MIN_WIDTH    = 16'd1000;
    localparam logic [CFG_W-1:0] RST_MAX_WIDTH    = 16'd2000;
    localparam logic [CFG_W-1:0] RST_DEAD_LOW     = 16'd1497;
    localparam logic [CFG_W-1:0] RST_DEAD_HIGH    = 16'd1503;
    localparam logic [CFG_W-1:0] RST_CENTER_WIDTH = 16'd1500;

    typedef struct packed {
        logic [CFG_W-1:0] min_width;
        logic [CFG_W-1:0] max_width;
        logic [CFG_W-1:0] dead_low;
        logic [CFG_W-1:0] dead_high;
        logic [CFG_W-1:0] center_width;
    } t_cfg;

endpackage

@@ hdl/rpwc_ram.sv @@
module rpwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rpwc_shape.sv @@
module rpwc_shape (
    input  rpwc_pkg::t_cfg                 i_cfg,
    input  logic [rpwc_pkg::TS_W-1:0]      i_raw,
    output logic [rpwc_pkg::WID_W-1:0]     o_width
);
    import rpwc_pkg::*;

    logic [TS_W-1:0]  min_ext;
    logic [TS_W-1:0]  max_ext;
    logic [TS_W-1:0]  lo_clamp;
    logic [TS_W-1:0]  hi_clamp;
    logic [WID_W-1:0] clamped;

    assign min_ext  = TS_W'(i_cfg.min_width);
    assign max_ext  = TS_W'(i_cfg.max_width);
    assign lo_clamp = (i_raw <= min_ext) ? min_ext : i_raw;
    assign hi_clamp = (lo_clamp >= max_ext) ? max_ext : lo_clamp;
    assign clamped  = hi_clamp[WID_W-1:0];

    always_comb begin
        if (clamped > i_cfg.dead_low && clamped < i_cfg.dead_high) begin
            o_width = i_cfg.center_width;
        end else begin
            o_width = clamped;
        end
    end

endmodule

@@ hdl/rc_pwm_pulse_width_capture.sv @@
// A falling edge passes through the start-time read, the difference, and the clamp and
// deadband into the output register; a stalled output can hold it between these registers.
// Throughput: one edge event per cycle while the output is not stalled; the start-time
// memory takes one write or one read per event, so events never contend for it.
// Reset clears the limits to their defaults and marks every start time as zero
// at once; the block is ready in the first cycle after reset.
module rc_pwm_pulse_width_capture #(
    parameter int CHANNELS = rpwc_pkg::CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rpwc_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [rpwc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rpwc_pkg::S_DATA_W-1:0]   s_axis_tdata,  // channel[1:0], timestamp[33:2]
    input  logic                            s_axis_tuser,  // level
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rpwc_pkg::M_DATA_W-1:0]   m_axis_tdata   // out_channel[1:0], width[17:2]
);
    import rpwc_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_cfg r_cfg;

    logic [CH_W-1:0] in_ch;
    logic [TS_W-1:0] in_ts;
    logic [AW+1:0]   ch_ext;
    logic [AW-1:0]   addr;
    logic            ch_ok;
    logic            s_acc;
    logic            ram_we;
    logic            ram_re;
    logic [TS_W-1:0] ram_rdata;

    logic [CHANNELS-1:0] r_written;

    logic            r_s1_vld;
    logic            r_s1_hit;
    logic [CH_W-1:0] r_s1_ch;
    logic [TS_W-1:0] r_s1_ts;
    logic [TS_W-1:0] start_time;

    logic            r_s2_vld;
    logic [CH_W-1:0] r_s2_ch;
    logic [TS_W-1:0] r_s2_diff;

    logic             r_out_vld;
    logic [CH_W-1:0]  r_out_ch;
    logic [WID_W-1:0] r_out_width;
    logic [WID_W-1:0] shaped;

    logic out_free;
    logic s2_free;
    logic s1_free;

    assign in_ch  = s_axis_tdata[CH_W-1:0];
    assign in_ts  = s_axis_tdata[CH_W+TS_W-1:CH_W];
    assign ch_ext = (AW+2)'(in_ch);
    assign addr   = ch_ext[AW-1:0];
    assign ch_ok  = ch_ext < (AW+2)'(CHANNELS);

    assign out_free = !r_out_vld || m_axis_tready;
    assign s2_free  = !r_s2_vld || out_free;
    assign s1_free  = !r_s1_vld || s2_free;

    assign s_axis_tready = s1_free;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign ram_we        = s_acc && ch_ok && s_axis_tuser;
    assign ram_re        = s_acc && ch_ok && !s_axis_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_width    <= RST_MIN_WIDTH;
            r_cfg.max_width    <= RST_MAX_WIDTH;
            r_cfg.dead_low     <= RST_DEAD_LOW;
            r_cfg.dead_high    <= RST_DEAD_HIGH;
            r_cfg.center_width <= RST_CENTER_WIDTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MIN_WIDTH:    r_cfg.min_width    <= i_cfg_wdata;
                CFG_MAX_WIDTH:    r_cfg.max_width    <= i_cfg_wdata;
                CFG_DEAD_LOW:     r_cfg.dead_low     <= i_cfg_wdata;
                CFG_DEAD_HIGH:    r_cfg.dead_high    <= i_cfg_wdata;
                CFG_CENTER_WIDTH: r_cfg.center_width <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    rpwc_ram #(
        .WIDTH(TS_W),
        .DEPTH(CHANNELS),
        .AW   (AW)
    ) u_start_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(addr),
        .i_wdata(in_ts),
        .i_re   (ram_re),
        .i_raddr(addr),
        .o_rdata(ram_rdata)
    );

    // Unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (ram_we) begin
            r_written[addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_vld <= ram_re;
            end
            if (s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
            if (out_free) begin
                r_out_vld <= r_s2_vld;
            end
        end
    end

    assign start_time = r_s1_hit ? ram_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_s1_hit <= r_written[addr];
            r_s1_ch  <= in_ch;
            r_s1_ts  <= in_ts;
        end
        if (s2_free && r_s1_vld) begin
            r_s2_ch   <= r_s1_ch;
            r_s2_diff <= r_s1_ts - start_time;
        end
        if (out_free && r_s2_vld) begin
            r_out_ch    <= r_s2_ch;
            r_out_width <= shaped;
        end
    end

    rpwc_shape u_shape (
        .i_cfg  (r_cfg),
        .i_raw  (r_s2_diff),
        .o_width(shaped)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = M_DATA_W'({r_out_width, r_out_ch});

endmodule

@@ hdl/rpwc_checker.sv @@
module rpwc_checker #(
    parameter int CHANNELS = rpwc_pkg::CHANNELS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rpwc_pkg::M_DATA_W-1:0]   m_axis_tdata
);
    import rpwc_pkg::*;

    logic quiet;

    assign quiet = !(s_axis_tvalid && s_axis_tready) && m_axis_tready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result transaction changed");

    a_out_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[CH_W-1:0] < CHANNELS)
        else $error("result for a channel out of range");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(quiet, 1) && $past(quiet, 2) && $past(quiet, 3) |-> !m_axis_tvalid)
        else $error("result appeared without a pending transaction");

endmodule

bind rc_pwm_pulse_width_capture rpwc_checker #(.CHANNELS(CHANNELS)) u_rpwc_checker (.*);
